@@ src/lightmac_aes_tag_core_assert.svh @@
// Assertion macros for the LightMAC tag core checker
`ifndef LIGHTMAC_AES_TAG_CORE_ASSERT_SVH
`define LIGHTMAC_AES_TAG_CORE_ASSERT_SVH
// implication checked every clock edge outside reset
`define LMA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define LMA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ src/lma_pkg.sv @@
// Package: AES tables, types and register indexes for the LightMAC tag core
`default_nettype none
package lma_pkg;
   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned MSG_BYTES = 12;
   localparam int unsigned CTR_BYTES = 4;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [1:0] {
      REG_K1_HIGH = 2'd0,
      REG_K1_LOW = 2'd1,
      REG_K2_HIGH = 2'd2,
      REG_K2_LOW = 2'd3
   } reg_index_type;

   typedef enum logic {
      JOB_COUNTER = 1'b0,
      JOB_FINAL = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [127:0] block;
   } job_type;

   typedef logic [7:0] sbox_table_type [256];
   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits in bits 127-8i .. 120-8i
   function automatic logic [7:0] blk_byte(input logic [127:0] b, input int unsigned i);
      blk_byte = b[127 - 8*i -: 8];
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] t [16];
      logic [7:0] m [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[r + 4*c] = SBOX[blk_byte(s, r + 4*((c + r) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[4*c]   = last ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
         m[4*c+1] = last ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
         m[4*c+2] = last ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
         m[4*c+3] = last ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) begin
         o[127 - 8*i -: 8] = m[i] ^ blk_byte(rk, i);
      end
      aes_round = o;
   endfunction

   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      key_next = {w0, w1, w2, w3};
   endfunction
endpackage
`default_nettype wire

@@ src/lma_stream_if.sv @@
// Valid/ready stream interface carrying one payload
`default_nettype none
interface lma_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/lightmac_aes_tag_core.sv @@
// Top level of the LightMAC AES-128 tag core
// Use:
//  req channel: one item per transfer (data_byte, has_byte, last_byte).
//  rsp channel: one 128-bit tag per item with last_byte set.
//  csr port: write enable, index 0..3 (key 1 high/low, key 2 high/low), 64-bit data.
//  The front end takes an item every cycle while the job queue has two
//  free slots; every twelfth byte and every last item queue an AES job.
//  The back end runs one AES-128 round per cycle in a round unit shared
//  by all jobs and takes a new job only when idle. Byte streams are taken
//  at one item per cycle while the queue has two free slots. A tag passes
//  the queue, the IDLE, RUN and HOLD states and the tag register.
//  Reset clears the queue, counter (to one), byte count, accumulator and
//  keys. When the receiver stalls the tag holds in the output register;
//  the back end stops at the next tag, the queue fills and req_ready falls.
`default_nettype none
module lightmac_aes_tag_core #(parameter int unsigned QueueDepth = lma_pkg::QUEUE_DEPTH) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic req_has_byte,
   input  wire logic req_last_byte,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [63:0] rsp_tag_high,
   output logic [63:0] rsp_tag_low,
   input  wire logic csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [63:0] csr_write_data
);
   import lma_pkg::*;
   logic [63:0] k1h_ff, k1l_ff, k2h_ff, k2l_ff;
   logic push, push_two, pop, pop_valid;
   job_type push_job, pop_job;
   logic [1:0] space;
   logic [127:0] tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1h_ff <= '0; k1l_ff <= '0; k2h_ff <= '0; k2l_ff <= '0;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_K1_HIGH: k1h_ff <= csr_write_data;
            REG_K1_LOW: k1l_ff <= csr_write_data;
            REG_K2_HIGH: k2h_ff <= csr_write_data;
            REG_K2_LOW: k2l_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   lma_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data_byte),
      .in_has(req_has_byte), .in_last(req_last_byte),
      .q_push(push), .q_push_extra(push_two), .q_push_job(push_job), .q_space(space)
   );

   lma_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .push_extra(push_two), .space(space),
      .pop_valid(pop_valid), .pop_job(pop_job), .pop(pop)
   );

   lma_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(pop_valid), .job(pop_job), .job_pop(pop),
      .key1({k1h_ff, k1l_ff}), .key2({k2h_ff, k2l_ff}),
      .out_valid(rsp_valid), .out_tag(tag), .out_ready(rsp_ready)
   );

   assign rsp_tag_high = tag[127:64];
   assign rsp_tag_low = tag[63:0];
endmodule
`default_nettype wire

@@ src/lma_front.sv @@
// Front end: byte buffering, counter and job formation
`default_nettype none
module lma_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic [7:0] in_data,
   input  wire logic in_has,
   input  wire logic in_last,
   output logic q_push,
   output logic q_push_extra,
   output lma_pkg::job_type q_push_job,
   input  wire logic [1:0] q_space
);
   import lma_pkg::*;
   logic [7:0] buf_ff [MSG_BYTES];
   logic [3:0] held_ff, held_in;
   logic [31:0] ctr_ff, ctr_in;
   logic take, full;
   logic [127:0] cblk, fblk;
   logic [3:0] fheld;
   logic [7:0] fb [MSG_BYTES];

   // a last item with a full block needs two slots
   assign in_ready = q_space >= 2'd2;
   assign take = in_valid && in_ready;
   assign full = in_has && (held_ff == 4'(MSG_BYTES - 1));

   always_comb begin
      for (int i = 0; i < MSG_BYTES; i++) begin
         fb[i] = (4'(i) == held_ff) ? in_data : buf_ff[i];
      end
      cblk[127:96] = ctr_ff;
      for (int i = 0; i < MSG_BYTES; i++) begin
         cblk[95 - 8*i -: 8] = fb[i];
      end
      fheld = full ? 4'd0 : (in_has ? held_ff + 4'd1 : held_ff);
      fblk = '0;
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (4'(i) < fheld) begin
            fblk[127 - 8*i -: 8] = fb[i];
         end
      end
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (4'(i) == fheld) begin
            fblk[127 - 8*i -: 8] = PAD_BYTE;
         end
      end
      held_in = held_ff;
      ctr_in = ctr_ff;
      if (take) begin
         if (full) begin
            held_in = '0;
            ctr_in = ctr_ff + 32'd1;
         end else if (in_has) begin
            held_in = held_ff + 4'd1;
         end
         if (in_last) begin
            held_in = '0;
            ctr_in = 32'd1;
         end
      end
   end

   always_comb begin
      q_push = take && (full || in_last);
      q_push_extra = take && full && in_last;
      q_push_job.kind = full ? JOB_COUNTER : JOB_FINAL;
      q_push_job.block = full ? cblk : fblk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         ctr_ff <= 32'd1;
      end else begin
         held_ff <= held_in;
         ctr_ff <= ctr_in;
      end
      if (take && in_has && !full) begin
         buf_ff[held_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

@@ src/lma_queue.sv @@
// Job queue between front and back end
`default_nettype none
module lma_queue #(parameter int unsigned Depth = lma_pkg::QUEUE_DEPTH) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire lma_pkg::job_type push_job,
   input  wire logic push_extra,
   output logic [1:0] space,
   output logic pop_valid,
   output lma_pkg::job_type pop_job,
   input  wire logic pop
);
   import lma_pkg::*;
   localparam int unsigned AW = $clog2(Depth);
   job_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff;
   logic [AW:0] free;
   logic [1:0] nwr;

   // second push slot carries the padded final job queued behind a counter job
   assign nwr = push ? (push_extra ? 2'd2 : 2'd1) : 2'd0;
   assign free = (AW+1)'(Depth) - cnt_ff;
   assign space = (free >= (AW+1)'(2)) ? 2'd2 : free[1:0];
   assign pop_valid = cnt_ff != '0;
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + AW'(nwr);
         rd_ff <= rd_ff + AW'(pop);
         cnt_ff <= cnt_ff + (AW+1)'(nwr) - (AW+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
      if (push && push_extra) begin
         mem_ff[wr_ff + AW'(1)] <= job_type'{JOB_FINAL, {PAD_BYTE, 120'd0}};
      end
   end
endmodule
`default_nettype wire

@@ src/lma_back.sv @@
// Back end: iterative AES-128, accumulator and tag register
`default_nettype none
module lma_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic job_valid,
   input  wire lma_pkg::job_type job,
   output logic job_pop,
   input  wire logic [127:0] key1,
   input  wire logic [127:0] key2,
   output logic out_valid,
   output logic [127:0] out_tag,
   input  wire logic out_ready
);
   import lma_pkg::*;
   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_type;
   state_type st_ff;
   logic [127:0] s_ff, rk_ff, acc_ff, tag_ff;
   logic [7:0] rcon_ff;
   logic [3:0] rnd_ff;
   job_kind_type kind_ff;
   logic tv_ff;
   logic [127:0] rk_n, s_n, key, inb;

   assign key = (job.kind == JOB_FINAL) ? key2 : key1;
   assign inb = (job.kind == JOB_FINAL) ? (job.block ^ acc_ff) : job.block;
   assign rk_n = key_next(rk_ff, rcon_ff);
   assign s_n = aes_round(s_ff, rk_n, rnd_ff == 4'd10);
   assign job_pop = job_valid && (st_ff == ST_IDLE);
   assign out_valid = tv_ff;
   assign out_tag = tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         tv_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         if (st_ff == ST_HOLD && (!tv_ff || out_ready)) begin
            tv_ff <= 1'b1;
         end else if (tv_ff && out_ready) begin
            tv_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  s_ff <= inb ^ key;
                  rk_ff <= key;
                  rcon_ff <= 8'h01;
                  rnd_ff <= 4'd1;
                  kind_ff <= job.kind;
                  st_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               s_ff <= s_n;
               rk_ff <= rk_n;
               rcon_ff <= xtime(rcon_ff);
               rnd_ff <= rnd_ff + 4'd1;
               if (rnd_ff == 4'd10) begin
                  if (kind_ff == JOB_COUNTER) begin
                     acc_ff <= acc_ff ^ s_n;
                     st_ff <= ST_IDLE;
                  end else begin
                     acc_ff <= '0;
                     st_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               if (!tv_ff || out_ready) begin
                  tag_ff <= s_ff;
                  st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ src/lma_checker.sv @@
// Port-level checker for the LightMAC tag core, bound to the top level
`default_nettype none
`include "lightmac_aes_tag_core_assert.svh"
module lma_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [63:0] rsp_tag_high,
   input wire logic [63:0] rsp_tag_low
);
   `LMA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LMA_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_tag_high) && $stable(rsp_tag_low))
   `LMA_ASSERT_IMP(a_req_ready_known, clock, reset, 1'b1, !$isunknown(req_ready))
   `LMA_ASSERT_IMP(a_reset_idle, clock, reset, $fell(reset), !rsp_valid)
endmodule

bind lightmac_aes_tag_core lma_checker u_lma_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_tag_high(rsp_tag_high), .rsp_tag_low(rsp_tag_low)
);
`default_nettype wire

@@ tb/sv/lightmac_aes_tag_core_tb.sv @@
// Self-checking testbench for the LightMAC AES-128 tag core: random byte streams, tag scoreboard
`default_nettype none
module lightmac_aes_tag_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lma_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic has_byte;
      logic last_byte;
   } msg_item_type;

   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
   } tag_type;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   reg_index_type csr_index = REG_K1_HIGH;
   logic [63:0] csr_write_data = '0;

   lma_stream_if #(.payload_type(msg_item_type)) req_if ();
   lma_stream_if #(.payload_type(tag_type)) rsp_if ();

   lightmac_aes_tag_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_data_byte    (req_if.payload.data_byte),
      .req_has_byte     (req_if.payload.has_byte),
      .req_last_byte    (req_if.payload.last_byte),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_tag_high     (rsp_if.payload.tag_high),
      .rsp_tag_low      (rsp_if.payload.tag_low),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   msg_item_type pending_items[$];
   tag_type expected_tags[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   logic quiet = 1'b0;
   logic long_stall_req = 1'b0;
   logic long_stall_done = 1'b0;
   int unsigned stall_left = 0;

   // predictor state
   logic [7:0] sub_table [256];
   logic [127:0] mac_acc;
   logic [7:0] held_bytes [12];
   int unsigned n_held;
   logic [31:0] blk_count;
   logic [127:0] counter_key;
   logic [127:0] final_key;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p = p ^ a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic void build_sub_table();
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
         end
         sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endfunction

   function automatic logic [127:0] cipher_block(input logic [127:0] key,
                                                 input logic [127:0] plain);
      logic [7:0] st [16];
      logic [7:0] nx [16];
      logic [7:0] rk [16];
      logic [7:0] kt [4];
      logic [7:0] rcon, a0, a1, a2, a3, al;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127 - 8*i -: 8];
         st[i] = plain[127 - 8*i -: 8] ^ rk[i];
      end
      rcon = 8'h01;
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               nx[r + 4*c] = sub_table[st[r + 4*((c + r) % 4)]];
            end
         end
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = nx[4*c]; a1 = nx[4*c+1]; a2 = nx[4*c+2]; a3 = nx[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               nx[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
               nx[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
               nx[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
               nx[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
            end
         end
         kt[0] = sub_table[rk[13]] ^ rcon;
         kt[1] = sub_table[rk[14]];
         kt[2] = sub_table[rk[15]];
         kt[3] = sub_table[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ kt[i];
         for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
         rcon = gf_mul(rcon, 8'h02);
         for (int i = 0; i < 16; i++) st[i] = nx[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
      return res;
   endfunction

   function automatic void clear_message();
      mac_acc = '0;
      n_held = 0;
      blk_count = 32'd1;
      for (int i = 0; i < 12; i++) held_bytes[i] = '0;
   endfunction

   function automatic void absorb_item(input msg_item_type it);
      logic [127:0] blk;
      if (it.has_byte) begin
         held_bytes[n_held] = it.data_byte;
         n_held++;
         if (n_held == MSG_BYTES) begin
            blk[127:96] = blk_count;
            for (int i = 0; i < 12; i++) blk[95 - 8*i -: 8] = held_bytes[i];
            mac_acc = mac_acc ^ cipher_block(counter_key, blk);
            blk_count = blk_count + 32'd1;
            n_held = 0;
         end
      end
      if (it.last_byte) begin
         blk = '0;
         for (int i = 0; i < n_held; i++) blk[127 - 8*i -: 8] = held_bytes[i];
         blk[127 - 8*n_held -: 8] = PAD_BYTE;
         blk = cipher_block(final_key, mac_acc ^ blk);
         expected_tags.push_back(tag_type'(blk));
         clear_message();
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 12)) begin
            req_if.valid <= 1'b1;
            req_if.payload <= pending_items.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long hold-off of the receiver
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) long_stall_done <= 1'b1;
      end else if (long_stall_req && !long_stall_done) begin
         stall_left <= 400;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset || stall_left > 0 || (long_stall_req && !long_stall_done)) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= quiet || $urandom_range(99) >= 12;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_tags.size() == 0) begin
               error_count++;
               $display("%0t tag with none expected: actual %h", $time, rsp_if.payload);
            end else begin
               tag_type exp_tag;
               exp_tag = expected_tags.pop_front();
               if (rsp_if.payload.tag_high !== exp_tag.tag_high) begin
                  error_count++;
                  $display("%0t tag_high mismatch: expected %h actual %h", $time,
                           exp_tag.tag_high, rsp_if.payload.tag_high);
               end
               if (rsp_if.payload.tag_low !== exp_tag.tag_low) begin
                  error_count++;
                  $display("%0t tag_low mismatch: expected %h actual %h", $time,
                           exp_tag.tag_low, rsp_if.payload.tag_low);
               end
            end
         end
         if (req_if.valid && req_if.ready) absorb_item(req_if.payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] b, input logic has, input logic last);
      msg_item_type it;
      it.data_byte = b;
      it.has_byte = has;
      it.last_byte = last;
      pending_items.push_back(it);
   endtask

   // message of len bytes, ended on the last byte or by a bare finish
   task automatic push_message(input int unsigned len, input bit bare_end,
                               inout int unsigned sent);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 4) push_item(8'($urandom), 1'b0, 1'b0);
         push_item(8'($urandom), 1'b1, !bare_end && i == len - 1);
         sent++;
      end
      if (bare_end || len == 0) begin
         push_item(8'($urandom), 1'b0, 1'b1);
         sent++;
      end
   endtask

   task automatic push_random(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 5) begin
            len = $urandom_range(60, 100);
         end else begin
            len = $urandom_range(0, 30);
         end
         push_message(len, $urandom_range(3) == 0, sent);
      end
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req_if.valid || expected_tags.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
   endtask

   task automatic load_keys(input logic [127:0] k1, input logic [127:0] k2);
      write_reg(REG_K1_HIGH, k1[127:64]);
      write_reg(REG_K1_LOW, k1[63:0]);
      write_reg(REG_K2_HIGH, k2[127:64]);
      write_reg(REG_K2_LOW, k2[63:0]);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      counter_key = k1;
      final_key = k2;
   endtask

   function automatic logic [127:0] random_key();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   initial begin
      int unsigned n;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      build_sub_table();
      counter_key = '0;
      final_key = '0;
      clear_message();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero keys: field extremes and the message boundary cases
      load_keys('0, '0);
      n = 0;
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'hff, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      for (int i = 0; i < 11; i++) push_item(8'(i * 23 + 1), 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      for (int i = 0; i < 12; i++) push_item(8'hff - 8'(i), 1'b1, i == 11);
      drain();
      push_message(12, 1'b1, n);
      push_message(24, 1'b0, n);
      push_random(150);
      drain();

      load_keys('1, '1);
      push_random(150);
      drain();

      // receiver holds off while the sender keeps offering
      load_keys(random_key(), random_key());
      long_stall_req <= 1'b1;
      push_random(200);
      drain();

      load_keys(random_key(), '0);
      quiet <= 1'b1;
      push_random(150);
      drain();
      quiet <= 1'b0;

      load_keys('0, random_key());
      push_random(150);
      drain();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+src
src/lma_pkg.sv
src/lma_stream_if.sv
src/lma_front.sv
src/lma_queue.sv
src/lma_back.sv
src/lightmac_aes_tag_core.sv
src/lma_checker.sv
tb/sv/lightmac_aes_tag_core_tb.sv
